[rtl/bpc_pkg.sv]
// Package: shared constants, types and helpers of the pressure compensation block.
package bpc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned UT_W      = 16;
  localparam int unsigned UP_W      = 19;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned IDX_W     = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [IDX_W-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [IDX_W-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MC_MD   = 3'd4;
  localparam logic [IDX_W-1:0] REG_OSS     = 3'd5;

  localparam logic [31:0] TEMP_OFFSET  = 32'd4000;
  localparam logic [31:0] PRESS_SCALE  = 32'd50000;
  localparam logic [31:0] POLY_SQ      = 32'd3038;
  localparam logic [31:0] POLY_LIN_NEG = 32'd0 - 32'd7537;
  localparam logic [31:0] POLY_OFS     = 32'd3791;
  localparam logic [31:0] AC4_BIAS     = 32'd32768;
  localparam logic [31:0] ROUND_TEMP   = 32'd8;
  localparam logic [31:0] ROUND_TWO    = 32'd2;
  localparam logic [31:0] TEMP_MAX     = 32'd32767;
  localparam logic [31:0] TEMP_MIN     = 32'hFFFF_8000;

  // Sideband that rides along the divider pipelines
  typedef struct packed {
    logic [DATA_W-1:0] x1;
    logic [UP_W-1:0]   up;
    logic [TEMP_W-1:0] temp;
    logic              neg;
    logic              hi;
    logic              err;
  } bpc_side_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

[rtl/bpc_div.sv]
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
module bpc_div import bpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  input  bpc_side_t         side_i,
  output logic              out_valid_o,
  output logic [DATA_W-1:0] quotient_o,
  output bpc_side_t         side_o
);

  logic [DIV_STEPS:0] v_q;
  logic [DATA_W-1:0]  rem_q  [DIV_STEPS+1];
  logic [DATA_W-1:0]  dvd_q  [DIV_STEPS+1];
  logic [DATA_W-1:0]  dvs_q  [DIV_STEPS+1];
  bpc_side_t          side_q [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STEPS-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      dvd_q[0]  <= dividend_i;
      dvs_q[0]  <= divisor_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            ge;
    assign trial = {rem_q[k-1], dvd_q[k-1][DATA_W-1]};
    assign diff  = trial - {1'b0, dvs_q[k-1]};
    assign ge    = !diff[DATA_W];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        dvd_q[k]  <= {dvd_q[k-1][DATA_W-2:0], ge};
        dvs_q[k]  <= dvs_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[DIV_STEPS];
  assign quotient_o  = dvd_q[DIV_STEPS];
  assign side_o      = side_q[DIV_STEPS];

endmodule

[rtl/barometric_pressure_compensation.sv]
// Top level: barometric temperature and pressure compensation pipeline.
// Structure: two 33-stage dividers plus 12 arithmetic stages, at most one
//   multiplier level per stage.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset: asynchronous active low; clears all valid bits and the coefficients
//   and oversampling setting to zero. Payload registers are not reset.
module barometric_pressure_compensation import bpc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [UT_W-1:0]          raw_temperature_i,
  input  logic [UP_W-1:0]          raw_pressure_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [TEMP_W-1:0] temperature_tenths_o,
  output logic signed [DATA_W-1:0] pressure_pa_o,
  output logic                     divide_error_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IDX_W-1:0]         cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Config registers, always writable; change only while idle (not enforced).
  // ---------------------------------------------------------------------------
  logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;
  logic [1:0]  oss_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_ac2_q <= '0;
      ac3_ac4_q <= '0;
      ac5_ac6_q <= '0;
      b1_b2_q   <= '0;
      mc_md_q   <= '0;
      oss_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_AC1_AC2: ac1_ac2_q <= cfg_data_i;
        REG_AC3_AC4: ac3_ac4_q <= cfg_data_i;
        REG_AC5_AC6: ac5_ac6_q <= cfg_data_i;
        REG_B1_B2:   b1_b2_q   <= cfg_data_i;
        REG_MC_MD:   mc_md_q   <= cfg_data_i;
        REG_OSS:     oss_q     <= cfg_data_i[1:0];
        default: begin
          // indexes beyond the list are dropped
        end
      endcase
    end
  end

  // Coefficients, extended to 32 bits
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(ac1_ac2_q[31:16]);
  assign ac2 = sx16(ac1_ac2_q[15:0]);
  assign ac3 = sx16(ac3_ac4_q[31:16]);
  assign ac4 = {16'd0, ac3_ac4_q[15:0]};
  assign ac5 = {16'd0, ac5_ac6_q[31:16]};
  assign ac6 = {16'd0, ac5_ac6_q[15:0]};
  assign b1  = sx16(b1_b2_q[31:16]);
  assign b2  = sx16(b1_b2_q[15:0]);
  assign mc  = sx16(mc_md_q[31:16]);
  assign md  = sx16(mc_md_q[15:0]);

  // ---------------------------------------------------------------------------
  // Global pipeline enable: every stage advances unless the output item is
  // held by the consumer. Valid bits travel with the data, so a stall neither
  // drops nor repeats an item.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic s1_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q, s9_v_q;
  logic s10_v_q, s11_v_q, s12_v_q;
  logic d1_v, d2_v;

  // Stage 1: first temperature product (UT - AC6) * AC5
  logic [31:0]     s1_prod_q;
  logic [UP_W-1:0] s1_up_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= ({16'd0, raw_temperature_i} - ac6) * ac5;
      s1_up_q   <= raw_pressure_i;
    end
  end

  // Temperature division MC*2^11 / (X1 + MD), signed, via magnitudes
  logic [31:0] t_x1, t_den, t_num, t_num_abs, t_den_abs;
  bpc_side_t   d1_side_in, d1_side;
  logic [31:0] d1_quo;

  assign t_x1      = asr32(s1_prod_q, 15);
  assign t_den     = t_x1 + md;
  assign t_num     = mc << 11;
  assign t_num_abs = t_num[31] ? (32'd0 - t_num) : t_num;
  assign t_den_abs = t_den[31] ? (32'd0 - t_den) : t_den;

  always_comb begin
    d1_side_in      = '0;
    d1_side_in.x1   = t_x1;
    d1_side_in.up   = s1_up_q;
    d1_side_in.neg  = t_num[31] ^ t_den[31];
    d1_side_in.err  = (t_den == 32'd0);
  end

  bpc_div u_div_temp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s1_v_q),
    .dividend_i  (t_num_abs),
    .divisor_i   (t_den_abs),
    .side_i      (d1_side_in),
    .out_valid_o (d1_v),
    .quotient_o  (d1_quo),
    .side_o      (d1_side)
  );

  // Stage 3: B5, saturated temperature, B6
  logic [31:0] t_x2, t_b5, t_raw;
  logic [15:0] t_sat;
  assign t_x2  = d1_side.neg ? (32'd0 - d1_quo) : d1_quo;
  assign t_b5  = d1_side.x1 + t_x2;
  assign t_raw = asr32(t_b5 + ROUND_TEMP, 4);

  always_comb begin
    if ($signed(t_raw) > $signed(TEMP_MAX)) begin
      t_sat = TEMP_MAX[15:0];
    end else if ($signed(t_raw) < $signed(TEMP_MIN)) begin
      t_sat = TEMP_MIN[15:0];
    end else begin
      t_sat = t_raw[15:0];
    end
  end

  logic [31:0]     s3_b6_q;
  logic [15:0]     s3_temp_q, s4_temp_q, s5_temp_q, s6_temp_q, s7_temp_q, s8_temp_q;
  logic [15:0]     s9_temp_q;
  logic [UP_W-1:0] s3_up_q, s4_up_q, s5_up_q, s6_up_q, s7_up_q;
  logic            s3_err_q, s4_err_q, s5_err_q, s6_err_q, s7_err_q, s8_err_q;
  logic            s9_err_q;

  // Stage 4: B6^2, AC2*B6, AC3*B6
  logic [31:0] s4_sqp_q, s4_ac2b6_q, s4_ac3b6_q;
  // Stage 5: SQ = B6^2 >> 12
  logic [31:0] s5_sq_q, s5_ac2b6_q, s5_ac3b6_q;
  // Stage 6: B2*SQ, B1*SQ
  logic [31:0] s6_b2sq_q, s6_b1sq_q, s6_ac2b6_q, s6_ac3b6_q;
  // Stage 7: B3 and X3 of the B4 term
  logic [31:0] s7_b3_q, s7_x3_q;
  // Stage 8: B4 and UP - B3
  logic [31:0] s8_b4_q, s8_diff_q;
  // Stage 9: B7
  logic [31:0] s9_b7_q, s9_b4_q;

  logic [31:0] c7_x3a, c7_b3, c7_x3b;
  assign c7_x3a = asr32(s6_b2sq_q, 11) + asr32(s6_ac2b6_q, 11);
  assign c7_b3  = asr32((((ac1 << 2) + c7_x3a) << oss_q) + ROUND_TWO, 2);
  assign c7_x3b = asr32(asr32(s6_ac3b6_q, 13) + asr32(s6_b1sq_q, 16) + ROUND_TWO, 2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_b6_q    <= t_b5 - TEMP_OFFSET;
      s3_temp_q  <= t_sat;
      s3_up_q    <= d1_side.up;
      s3_err_q   <= d1_side.err;

      s4_sqp_q   <= s3_b6_q * s3_b6_q;
      s4_ac2b6_q <= ac2 * s3_b6_q;
      s4_ac3b6_q <= ac3 * s3_b6_q;
      s4_temp_q  <= s3_temp_q;
      s4_up_q    <= s3_up_q;
      s4_err_q   <= s3_err_q;

      s5_sq_q    <= asr32(s4_sqp_q, 12);
      s5_ac2b6_q <= s4_ac2b6_q;
      s5_ac3b6_q <= s4_ac3b6_q;
      s5_temp_q  <= s4_temp_q;
      s5_up_q    <= s4_up_q;
      s5_err_q   <= s4_err_q;

      s6_b2sq_q  <= b2 * s5_sq_q;
      s6_b1sq_q  <= b1 * s5_sq_q;
      s6_ac2b6_q <= s5_ac2b6_q;
      s6_ac3b6_q <= s5_ac3b6_q;
      s6_temp_q  <= s5_temp_q;
      s6_up_q    <= s5_up_q;
      s6_err_q   <= s5_err_q;

      s7_b3_q    <= c7_b3;
      s7_x3_q    <= c7_x3b;
      s7_temp_q  <= s6_temp_q;
      s7_up_q    <= s6_up_q;
      s7_err_q   <= s6_err_q;

      s8_b4_q    <= (ac4 * (s7_x3_q + AC4_BIAS)) >> 15;
      s8_diff_q  <= {13'd0, s7_up_q} - s7_b3_q;
      s8_temp_q  <= s7_temp_q;
      s8_err_q   <= s7_err_q;

      s9_b7_q    <= s8_diff_q * (PRESS_SCALE >> oss_q);
      s9_b4_q    <= s8_b4_q;
      s9_temp_q  <= s8_temp_q;
      s9_err_q   <= s8_err_q || (s8_b4_q == 32'd0);
    end
  end

  // Pressure division: B7*2/B4 when B7 is below half range, else (B7/B4)*2
  logic        p_hi;
  logic [31:0] p_dvd, d2_quo;
  bpc_side_t   d2_side_in, d2_side;
  assign p_hi  = s9_b7_q[31];
  assign p_dvd = p_hi ? s9_b7_q : (s9_b7_q << 1);

  always_comb begin
    d2_side_in      = '0;
    d2_side_in.temp = s9_temp_q;
    d2_side_in.hi   = p_hi;
    d2_side_in.err  = s9_err_q;
  end

  bpc_div u_div_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s9_v_q),
    .dividend_i  (p_dvd),
    .divisor_i   (s9_b4_q),
    .side_i      (d2_side_in),
    .out_valid_o (d2_v),
    .quotient_o  (d2_quo),
    .side_o      (d2_side)
  );

  // Stages 10..12: final polynomial correction of the pressure
  logic [31:0] s10_p_q, s10_pa_q, s11_p_q, s11_sq_q, s11_lin_q;
  logic [31:0] s12_p_q, s12_m_q, s12_x2_q;
  logic [15:0] s10_temp_q, s11_temp_q, s12_temp_q;
  logic        s10_err_q, s11_err_q, s12_err_q;
  logic [31:0] p_div, p_fin;

  assign p_div = d2_side.hi ? (d2_quo << 1) : d2_quo;
  assign p_fin = s12_p_q + asr32(asr32(s12_m_q, 16) + s12_x2_q + POLY_OFS, 4);

  logic [15:0] out_temp_q;
  logic [31:0] out_press_q;
  logic        out_err_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_p_q    <= p_div;
      s10_pa_q   <= asr32(p_div, 8);
      s10_temp_q <= d2_side.temp;
      s10_err_q  <= d2_side.err;

      s11_p_q    <= s10_p_q;
      s11_sq_q   <= s10_pa_q * s10_pa_q;
      s11_lin_q  <= POLY_LIN_NEG * s10_p_q;
      s11_temp_q <= s10_temp_q;
      s11_err_q  <= s10_err_q;

      s12_p_q    <= s11_p_q;
      s12_m_q    <= s11_sq_q * POLY_SQ;
      s12_x2_q   <= asr32(s11_lin_q, 16);
      s12_temp_q <= s11_temp_q;
      s12_err_q  <= s11_err_q;

      // zero both results on a divide by zero
      out_temp_q  <= s12_err_q ? 16'd0 : s12_temp_q;
      out_press_q <= s12_err_q ? 32'd0 : p_fin;
      out_err_q   <= s12_err_q;
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      s9_v_q      <= 1'b0;
      s10_v_q     <= 1'b0;
      s11_v_q     <= 1'b0;
      s12_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_v_q      <= in_valid_i;
      s3_v_q      <= d1_v;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      s8_v_q      <= s7_v_q;
      s9_v_q      <= s8_v_q;
      s10_v_q     <= d2_v;
      s11_v_q     <= s10_v_q;
      s12_v_q     <= s11_v_q;
      out_valid_q <= s12_v_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign temperature_tenths_o = out_temp_q;
  assign pressure_pa_o        = out_press_q;
  assign divide_error_o       = out_err_q;

  // Assertions
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_temp_q == 16'd0 && out_press_q == 32'd0)
    else $error("error item with nonzero results");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s1_v_q) && $stable(s9_v_q) && $stable(s12_v_q))
    else $error("pipeline valid moved during stall");

  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s12_v_q))
    else $error("result appeared without an item in the last stage");

  a_oss_only_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(oss_q))
    else $error("oversampling changed without a write");

endmodule

[tb/barometric_pressure_compensation_tb.sv]
// Testbench for the barometric temperature and pressure compensation block.
`timescale 1ns / 1ps

module barometric_pressure_compensation_tb import bpc_pkg::*;;

  typedef struct {
    logic signed [15:0] temp;
    logic signed [31:0] press;
    logic               err;
  } reading_t;

  // Calibration shadow and the expected readings; checks come back by report task.
  class reading_board;
    logic [31:0] ac12, ac34, ac56, b12, mcmd;
    logic [1:0]  oss;
    reading_t    pending[$];
    int          errors;

    function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_AC1_AC2: ac12 = v;
        REG_AC3_AC4: ac34 = v;
        REG_AC5_AC6: ac56 = v;
        REG_B1_B2:   b12  = v;
        REG_MC_MD:   mcmd = v;
        REG_OSS:     oss  = v[1:0];
        default: ;
      endcase
    endfunction

    // Compensate one raw sample; all 32-bit arithmetic wraps.
    function reading_t compensate(logic [15:0] ut, logic [18:0] up);
      reading_t r;
      logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
      logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, t, den, p;
      logic [31:0] ac4, ac5, ac6, b4, b7;
      longint q;
      ac1 = {{16{ac12[31]}}, ac12[31:16]};
      ac2 = {{16{ac12[15]}}, ac12[15:0]};
      ac3 = {{16{ac34[31]}}, ac34[31:16]};
      ac4 = {16'd0, ac34[15:0]};
      ac5 = {16'd0, ac56[31:16]};
      ac6 = {16'd0, ac56[15:0]};
      b1 = {{16{b12[31]}}, b12[31:16]};
      b2 = {{16{b12[15]}}, b12[15:0]};
      mc = {{16{mcmd[31]}}, mcmd[31:16]};
      md = {{16{mcmd[15]}}, mcmd[15:0]};
      r.temp = 0; r.press = 0; r.err = 1;
      x1 = $signed(32'(({16'd0, ut} - ac6) * ac5)) >>> 15;
      den = x1 + md;
      if (den == 0) return r;
      q = longint'(mc <<< 11) / longint'(den);
      x2 = 32'(q);
      b5 = x1 + x2;
      t = (b5 + 8) >>> 4;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      b6 = b5 - 32'sd4000;
      sq = 32'(b6 * b6) >>> 12;
      x1 = 32'(b2 * sq) >>> 11;
      x2 = 32'(ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = 32'(((32'(ac1 * 4) + x3) <<< oss) + 2) >>> 2;
      x1 = 32'(ac3 * b6) >>> 13;
      x2 = 32'(b1 * sq) >>> 16;
      x3 = 32'(x1 + x2 + 2) >>> 2;
      b4 = 32'(ac4 * 32'(x3 + 32768)) >> 15;
      if (b4 == 0) return r;
      b7 = 32'(({13'd0, up} - b3) * (32'd50000 >> oss));
      if (b7 < 32'h8000_0000) p = 32'((b7 * 2) / b4);
      else p = 32'((b7 / b4) * 2);
      x1 = p >>> 8;
      x1 = 32'(x1 * x1);
      x1 = 32'(x1 * 3038) >>> 16;
      x2 = 32'(-32'sd7537 * p) >>> 16;
      p = p + (32'(x1 + x2 + 3791) >>> 4);
      r.temp = t[15:0]; r.press = p; r.err = 0;
      return r;
    endfunction

    function void note_sample(logic [15:0] ut, logic [18:0] up);
      pending.push_back(compensate(ut, up));
    endfunction

    task check_reading(reading_t got);
      reading_t exp;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      exp = pending.pop_front();
      if (got.temp !== exp.temp)
        report_mismatch($sformatf("temperature %0d, expected %0d", got.temp, exp.temp));
      if (got.press !== exp.press)
        report_mismatch($sformatf("pressure %0d, expected %0d", got.press, exp.press));
      if (got.err !== exp.err)
        report_mismatch($sformatf("divide_error %b, expected %b", got.err, exp.err));
    endtask

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [15:0] raw_t = 0;
  logic [18:0] raw_p = 0;
  logic out_valid, out_ready = 0;
  logic signed [15:0] temp_o;
  logic signed [31:0] press_o;
  logic div_err;
  logic cfg_valid = 0, cfg_ready;
  logic [IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  reading_board board;
  bit hold_sink = 0;   // long receiver hold-off request
  bit mute_sink = 0;   // no random stalls

  always #2 clk = ~clk;

  barometric_pressure_compensation dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .raw_temperature_i(raw_t), .raw_pressure_i(raw_p),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .temperature_tenths_o(temp_o), .pressure_pa_o(press_o), .divide_error_o(div_err),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Write one calibration register; the block must be idle.
  task write_cal(logic [IDX_W-1:0] idx, logic [31:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, v);
  endtask

  task write_all(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                 logic [31:0] e, logic [1:0] o);
    write_cal(REG_AC1_AC2, a);
    write_cal(REG_AC3_AC4, b);
    write_cal(REG_AC5_AC6, c);
    write_cal(REG_B1_B2, d);
    write_cal(REG_MC_MD, e);
    write_cal(REG_OSS, {30'd0, o});
    cfg_valid <= 0;
  endtask

  // Offer one item; gap first so valid stays up across back-to-back items.
  task send_sample(logic [15:0] ut, logic [18:0] up, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; raw_t <= ut; raw_p <= up;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(ut, up);
  endtask

  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // Typical datasheet calibration, with small random perturbations.
  task typical_cal(logic [1:0] o);
    write_all({16'd408, 16'hFFB8}, {16'hC1A9 ^ 16'($urandom_range(0, 31)), 16'd32741},
              {16'd32757, 16'd23153}, {16'd6190, 16'd4}, {16'h8000 ^ 16'($urandom_range(0, 15)),
              16'd2868}, o);
  endtask

  task random_batch(int n, bit realistic);
    for (int i = 0; i < n; i++) begin
      if (realistic)
        send_sample(16'($urandom_range(15000, 40000)), 19'($urandom_range(0, 524287)),
                    pick_gap());
      else
        send_sample(16'($urandom), 19'($urandom), pick_gap());
    end
  endtask

  // Receiver: random stalls, a long hold-off on request.
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      g = mute_sink ? 0 : pick_gap();
      out_ready <= (g == 0);
      if (g > 0) repeat (g - 1) @(posedge clk);
    end
  end

  // Sample outputs at the edge, where the handshake is decided.
  always @(posedge clk) begin
    reading_t got;
    if (rst_n && out_valid && out_ready) begin
      got.temp = temp_o; got.press = press_o; got.err = div_err;
      board.check_reading(got);
    end
  end

  initial begin
    board = new();
    board.write_reg(REG_AC1_AC2, 0); board.write_reg(REG_AC3_AC4, 0);
    board.write_reg(REG_AC5_AC6, 0); board.write_reg(REG_B1_B2, 0);
    board.write_reg(REG_MC_MD, 0);   board.write_reg(REG_OSS, 0);
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset coefficients: zero temperature divisor.
    send_sample(16'd0, 19'd0, 0);
    send_sample(16'hFFFF, 19'h7FFFF, 0);
    drain();
    // Datasheet example and field extremes.
    write_all({16'd408, 16'hFFB8}, {16'hC1A9, 16'd32741}, {16'd32757, 16'd23153},
              {16'd6190, 16'd4}, {16'h8000, 16'd2868}, 2'd0);
    send_sample(16'd27898, 19'd23843, 0);
    send_sample(16'd0, 19'd0, 0);
    send_sample(16'hFFFF, 19'h7FFFF, 0);
    send_sample(16'h5555, 19'h2AAAA, 0);
    send_sample(16'hAAAA, 19'h55555, 0);
    drain();
    // Zero temperature divisor: AC5=0 and MD=0.
    write_all(32'h7FFF_8000, 32'h8000_FFFF, 32'h0000_FFFF, 32'h7FFF_8000, 32'h0001_0000, 2'd3);
    send_sample(16'd1234, 19'd4321, 0);
    drain();
    // Zero pressure divisor: AC4 = 0.
    write_all(32'h0198_FFB8, 32'hC1A9_0000, 32'h7FF5_5A71, 32'h182E_0004, 32'h8000_0B34, 2'd1);
    send_sample(16'd27898, 19'd23843, 0);
    drain();
    // Extreme coefficients: saturated temperature and wrapping pressure.
    write_all(32'h8000_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_7FFF, 32'h7FFF_0001, 2'd2);
    send_sample(16'hFFFF, 19'd0, 0);
    send_sample(16'd0, 19'h7FFFF, 0);
    send_sample(16'd100, 19'd100, 0);
    drain();
    write_all(32'hFFFF_FFFF, 32'hFFFF_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_7FFF, 2'd3);
    send_sample(16'd0, 19'd0, 0);
    send_sample(16'hFFFF, 19'h7FFFF, 0);
    drain();

    // Random phases over all oversampling settings.
    for (int ph = 0; ph < 8; ph++) begin
      typical_cal(2'(ph));
      random_batch(150, 1);
      drain();
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
      random_batch(70, 0);
      drain();
    end

    // Stall the receiver while the sender keeps offering: block fills up.
    typical_cal(2'd2);
    hold_sink = 1;
    mute_sink = 1;
    random_batch(120, 1);
    mute_sink = 0;
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
